[sv/lpte_pkg.sv]
// ----------------------------------------------------------------------------
// lpte_pkg
// Shared types and constants for the long-press timed enable block.
// ----------------------------------------------------------------------------
package lpte_pkg;

  // Width of the elapsed-time counter
  localparam int unsigned TimeBits = 32;
  localparam int unsigned WinBits  = 32;
  localparam int unsigned CmpBits  = (TimeBits > WinBits) ? TimeBits : WinBits;

  localparam int unsigned DebBits    = 8;
  localparam int unsigned HoldBits   = 16;
  localparam int unsigned SettleBits = 9;

  localparam logic [DebBits-1:0]  DebounceRst  = DebBits'(50);
  localparam logic [HoldBits-1:0] LongPressRst = HoldBits'(3000);
  localparam logic [WinBits-1:0]  WindowRst    = WinBits'(300000);

  // Opcodes of the input beat; the fourth code is ignored
  localparam logic [1:0] OpTick    = 2'd0;
  localparam logic [1:0] OpEnable  = 2'd1;
  localparam logic [1:0] OpDisable = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CfgDebounce  = 2'd0;
  localparam logic [1:0] CfgLongPress = 2'd1;
  localparam logic [1:0] CfgWindow    = 2'd2;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_OPENED  = 2'd1,
    EV_CLOSED  = 2'd2,
    EV_REFUSED = 2'd3
  } event_e;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_PRESSED = 2'd1,
    PH_LONG    = 2'd2
  } phase_e;

endpackage

[sv/lpte_if.sv]
// ----------------------------------------------------------------------------
// lpte interfaces
// Input, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface lpte_in_if import lpte_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic               raw_level;
  logic               connected;
  logic               radio_available;
  logic [WinBits-1:0] window_request;
  logic               feedback_request;

  modport source (output valid, opcode, raw_level, connected, radio_available,
                  window_request, feedback_request, input ready);
  modport sink   (input valid, opcode, raw_level, connected, radio_available,
                  window_request, feedback_request, output ready);
endinterface

interface lpte_out_if import lpte_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               window_open;
  logic               feedback_on;
  logic [WinBits-1:0] remaining;
  logic [1:0]         event_res;
  logic [1:0]         button_phase;

  modport source (output valid, window_open, feedback_on, remaining, event_res,
                  button_phase, input ready);
  modport sink   (input valid, window_open, feedback_on, remaining, event_res,
                  button_phase, output ready);
endinterface

interface lpte_cfg_if import lpte_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         index;
  logic [WinBits-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[sv/long_press_timed_enable.sv]
// ----------------------------------------------------------------------------
// long_press_timed_enable
// Debounced long-press detector that opens a timed enable window.
// ----------------------------------------------------------------------------
// Each accepted input beat passes the input register, then the result register.
// Throughput: one beat per cycle when out_o is not stalled; the input register
//   feeds one pass of counter/compare logic, updating state and result register.
// Reset: async active low; debounce state released, phase idle, window closed,
//   configuration back to its defaults, both pipeline stages empty.
module long_press_timed_enable import lpte_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  lpte_in_if.sink    in_i,
  lpte_cfg_if.sink   cfg_i,
  lpte_out_if.source out_o
);

  // configuration
  logic [DebBits-1:0]  debounce_q;
  logic [HoldBits-1:0] long_press_q;
  logic [WinBits-1:0]  default_win_q;

  // input stage
  logic               in_vld_q;
  logic [1:0]         op_q;
  logic               raw_q, conn_q, radio_q, fb_q;
  logic [WinBits-1:0] req_q;

  // block state
  logic                  last_raw_q, last_raw_d;
  logic                  stable_q, stable_d;
  logic [SettleBits-1:0] settle_q, settle_d;
  phase_e                phase_q, phase_d;
  logic [HoldBits-1:0]   hold_q, hold_d;
  logic                  open_q, open_d;
  logic [TimeBits-1:0]   elapsed_q, elapsed_d;
  logic [WinBits-1:0]    win_len_q, win_len_d;
  logic                  fb_want_q, fb_want_d;
  logic                  fb_shown_q, fb_shown_d;

  // result stage
  logic               out_vld_q;
  logic               res_open_q, res_fb_q;
  logic [WinBits-1:0] res_rem_q, res_rem_d;
  event_e             res_ev_q, ev_d;
  phase_e             res_phase_q;

  logic               advance;
  logic               is_tick, do_open;
  logic [WinBits-1:0] open_len;
  logic               open_fb;
  logic [CmpBits-1:0] el_x, len_x, diff_x;

  assign advance      = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready   = !in_vld_q || advance;
  assign cfg_i.ready  = 1'b1;

  // ---------------- configuration ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q    <= DebounceRst;
      long_press_q  <= LongPressRst;
      default_win_q <= WindowRst;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CfgDebounce:  debounce_q    <= cfg_i.data[DebBits-1:0];
        CfgLongPress: long_press_q  <= cfg_i.data[HoldBits-1:0];
        CfgWindow:    default_win_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // ---------------- input register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      op_q    <= in_i.opcode;
      raw_q   <= in_i.raw_level;
      conn_q  <= in_i.connected;
      radio_q <= in_i.radio_available;
      req_q   <= in_i.window_request;
      fb_q    <= in_i.feedback_request;
    end
  end

  // ---------------- next state and result ----------------
  always_comb begin
    last_raw_d = last_raw_q;
    stable_d   = stable_q;
    settle_d   = settle_q;
    phase_d    = phase_q;
    hold_d     = hold_q;
    open_d     = open_q;
    elapsed_d  = elapsed_q;
    win_len_d  = win_len_q;
    fb_want_d  = fb_want_q;
    fb_shown_d = fb_shown_q;
    ev_d       = EV_NONE;
    do_open    = 1'b0;
    is_tick    = (op_q == OpTick);
    open_len   = (op_q == OpEnable) ? req_q : '0;
    open_fb    = (op_q == OpEnable) ? fb_q : 1'b1;

    if (is_tick) begin
      if (open_q && (elapsed_q != '1)) begin
        elapsed_d = elapsed_q + TimeBits'(1);
      end
      // debounce
      if (raw_q != last_raw_q) begin
        settle_d = '0;
      end else if (settle_q != '1) begin
        settle_d = settle_q + SettleBits'(1);
      end
      if (settle_d > SettleBits'(debounce_q)) begin
        stable_d = raw_q;
      end
      last_raw_d = raw_q;

      // button machine; pressed is stable level low
      case (phase_q)
        PH_IDLE: begin
          if (!stable_d) begin
            phase_d = PH_PRESSED;
            hold_d  = '0;
          end
        end
        PH_PRESSED: begin
          if (stable_d) begin
            phase_d = PH_IDLE;
          end else begin
            if (hold_q != '1) begin
              hold_d = hold_q + HoldBits'(1);
            end
            if (hold_d >= long_press_q) begin
              phase_d = PH_LONG;
              do_open = 1'b1;
            end
          end
        end
        default: begin
          if (stable_d) begin
            phase_d = PH_IDLE;
          end
        end
      endcase
    end else if (op_q == OpEnable) begin
      do_open = 1'b1;
    end else if (op_q == OpDisable) begin
      if (open_q) begin
        open_d     = 1'b0;
        fb_shown_d = 1'b0;
        fb_want_d  = 1'b0;
        ev_d       = EV_CLOSED;
      end
    end

    if (do_open) begin
      if (!radio_q) begin
        open_d     = 1'b0;
        fb_shown_d = 1'b0;
        fb_want_d  = 1'b0;
        ev_d       = EV_REFUSED;
      end else begin
        win_len_d  = (open_len == '0) ? default_win_q : open_len;
        elapsed_d  = '0;
        open_d     = 1'b1;
        fb_want_d  = open_fb;
        fb_shown_d = open_fb && !conn_q;
        ev_d       = EV_OPENED;
      end
    end

    el_x  = CmpBits'(elapsed_d);
    len_x = CmpBits'(win_len_d);

    // window end check and feedback tracking, ticks only
    if (is_tick && open_d) begin
      if (el_x >= len_x) begin
        open_d     = 1'b0;
        fb_shown_d = 1'b0;
        fb_want_d  = 1'b0;
        ev_d       = EV_CLOSED;
      end else if (conn_q && fb_shown_d) begin
        fb_shown_d = 1'b0;
      end else if (!conn_q && !fb_shown_d && fb_want_d) begin
        fb_shown_d = 1'b1;
      end
    end

    diff_x    = len_x - el_x;
    res_rem_d = (open_d && (el_x < len_x)) ? diff_x[WinBits-1:0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_raw_q <= 1'b1;
      stable_q   <= 1'b1;
      settle_q   <= '0;
      phase_q    <= PH_IDLE;
      hold_q     <= '0;
      open_q     <= 1'b0;
      elapsed_q  <= '0;
      win_len_q  <= '0;
      fb_want_q  <= 1'b0;
      fb_shown_q <= 1'b0;
    end else if (advance) begin
      last_raw_q <= last_raw_d;
      stable_q   <= stable_d;
      settle_q   <= settle_d;
      phase_q    <= phase_d;
      hold_q     <= hold_d;
      open_q     <= open_d;
      elapsed_q  <= elapsed_d;
      win_len_q  <= win_len_d;
      fb_want_q  <= fb_want_d;
      fb_shown_q <= fb_shown_d;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= advance || (out_vld_q && !out_o.ready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_open_q  <= open_d;
      res_fb_q    <= open_d && fb_shown_d;
      res_rem_q   <= res_rem_d;
      res_ev_q    <= ev_d;
      res_phase_q <= phase_d;
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.window_open  = res_open_q;
  assign out_o.feedback_on  = res_fb_q;
  assign out_o.remaining    = res_rem_q;
  assign out_o.event_res    = res_ev_q;
  assign out_o.button_phase = res_phase_q;

endmodule

[sv/lpte_checker.sv]
// ----------------------------------------------------------------------------
// lpte_checker
// Port-level checks of the long-press timed enable result channel.
// ----------------------------------------------------------------------------
module lpte_checker import lpte_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic               window_open_i,
  input logic               feedback_on_i,
  input logic [WinBits-1:0] remaining_i,
  input logic [1:0]         event_res_i
);

  // a stalled result beat keeps its remaining time, window state and event
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(remaining_i)
      && $stable(window_open_i) && $stable(event_res_i))
    else $error("result beat changed while stalled");

  a_rem_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !window_open_i |-> remaining_i == '0)
    else $error("remaining nonzero with window closed");

  a_fb_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && feedback_on_i |-> window_open_i)
    else $error("feedback on with window closed");

  a_ev_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (event_res_i == EV_CLOSED || event_res_i == EV_REFUSED)
      |-> !window_open_i)
    else $error("close or refusal reported with window open");

  a_ev_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && event_res_i == EV_OPENED |-> window_open_i)
    else $error("open reported with window closed");

endmodule

bind long_press_timed_enable lpte_checker u_lpte_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .window_open_i (out_o.window_open),
  .feedback_on_i (out_o.feedback_on),
  .remaining_i   (out_o.remaining),
  .event_res_i   (out_o.event_res)
);
